FILE: design/sip_pkg.sv
// Shared types and constants for the segment intersection point block.
// No dependencies.
`default_nettype none

package sip_pkg;

    // Fixed width of the intersection coordinates on the result channel
    localparam int OUT_W = 24;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

endpackage

`default_nettype wire

FILE: design/sip_if.sv
// Channel interfaces for the segment intersection point block.
// Depends on sip_pkg.
`default_nettype none

interface sip_in_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface sip_out_if ();
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [sip_pkg::OUT_W-1:0]  cross_x;
    logic signed [sip_pkg::OUT_W-1:0]  cross_y;

    modport source (output valid, status, cross_x, cross_y, input ready);
    modport sink   (input valid, status, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

FILE: design/sip_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; quotient must be known to fit in QW bits.
`default_nettype none

module sip_div #(
    parameter int DW = 34,
    parameter int QW = 24,
    parameter int SW = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DW+QW-1:0] i_num,
    input  wire logic [DW-1:0]    i_den,
    input  wire logic [SW-1:0]    i_side,
    output logic      [QW-1:0]    o_quot,
    output logic      [SW-1:0]    o_side
);

    logic [DW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_low  [0:QW-1];
    logic [QW-1:0] r_q    [0:QW-1];
    logic [DW-1:0] r_den  [0:QW-1];
    logic [SW-1:0] r_side [0:QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign rem_in  = i_num[DW+QW-1:QW];
            assign low_in  = i_num[QW-1:0];
            assign q_in    = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign low_in  = r_low[s-1];
            assign q_in    = r_q[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});
        assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= {low_in[QW-2:0], 1'b0};
                r_q[s]    <= {q_in[QW-2:0], ge};
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_quot = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule

`default_nettype wire

FILE: design/segment_intersection_point.sv
// Segment intersection point: difference, product, determinant, classification
// and dividend stages, the dividers and an output register; throughput one
// transaction per cycle. The dividers give one quotient bit per pipeline stage.
// The whole pipeline advances together; it holds while a result waits.
// Synchronous active-low reset clears valid bits; threshold resets to 1.
`default_nettype none

module segment_intersection_point #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    sip_in_if.sink           i_in,
    sip_out_if.source        o_out
);
    import sip_pkg::*;

    // Widths: coordinate differences, products, determinant terms
    localparam int CW   = COORD_WIDTH;
    localparam int DFW  = CW + 1;
    localparam int PRW  = 2 * DFW;
    localparam int PW   = PRW + 1;
    localparam int DW   = PW - 1;          // magnitude of |den|, |tn| on a hit
    localparam int QW   = CW + FRAC_BITS;  // quotient bits
    localparam int NW   = DW + QW;         // divider numerator
    localparam int CMPW = (DW > 32) ? DW : 32;
    localparam int VW   = CW + FRAC_BITS + 2;
    localparam int SATW = (VW > OUT_W + 1) ? VW : OUT_W + 1;
    localparam int XSW  = 2 + 1 + CW;      // status, sign, start
    localparam int YSW  = 1 + CW;          // sign, start
    localparam int NV   = 5 + QW;          // valid bits before the output register

    // Threshold register
    logic [31:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 32'd1;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Global advance: all stages move unless a finished result is held
    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    logic [NV-1:0] r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid     <= {r_valid[NV-2:0], i_in.valid};
            r_out_valid <= r_valid[NV-1];
        end
    end

    // Stage 1: coordinate differences
    logic signed [DFW-1:0] r1_d12x, r1_d12y, r1_d34x, r1_d34y, r1_d13x, r1_d13y;
    logic signed [DFW-1:0] r1_dx, r1_dy;
    logic signed [CW-1:0]  r1_x1, r1_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d12x <= DFW'(i_in.a_start_x) - DFW'(i_in.a_end_x);
            r1_d12y <= DFW'(i_in.a_start_y) - DFW'(i_in.a_end_y);
            r1_d34x <= DFW'(i_in.b_start_x) - DFW'(i_in.b_end_x);
            r1_d34y <= DFW'(i_in.b_start_y) - DFW'(i_in.b_end_y);
            r1_d13x <= DFW'(i_in.a_start_x) - DFW'(i_in.b_start_x);
            r1_d13y <= DFW'(i_in.a_start_y) - DFW'(i_in.b_start_y);
            r1_dx   <= DFW'(i_in.a_end_x) - DFW'(i_in.a_start_x);
            r1_dy   <= DFW'(i_in.a_end_y) - DFW'(i_in.a_start_y);
            r1_x1   <= i_in.a_start_x;
            r1_y1   <= i_in.a_start_y;
        end
    end

    // Stage 2: the six cross products
    logic signed [PRW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DFW-1:0] r2_dx, r2_dy;
    logic signed [CW-1:0]  r2_x1, r2_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p0 <= PRW'(r1_d12x) * PRW'(r1_d34y);
            r2_p1 <= PRW'(r1_d12y) * PRW'(r1_d34x);
            r2_p2 <= PRW'(r1_d13x) * PRW'(r1_d34y);
            r2_p3 <= PRW'(r1_d13y) * PRW'(r1_d34x);
            r2_p4 <= PRW'(r1_d12y) * PRW'(r1_d13x);
            r2_p5 <= PRW'(r1_d12x) * PRW'(r1_d13y);
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
        end
    end

    // Stage 3: determinant and the two parameter numerators
    logic signed [PW-1:0]  r3_den, r3_tn, r3_un;
    logic signed [DFW-1:0] r3_dx, r3_dy;
    logic signed [CW-1:0]  r3_x1, r3_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den <= PW'(r2_p0) - PW'(r2_p1);
            r3_tn  <= PW'(r2_p2) - PW'(r2_p3);
            r3_un  <= PW'(r2_p4) - PW'(r2_p5);
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    // Stage 4: classification, without division. Numerators are flipped
    // with the determinant so that the range test is against a positive value.
    logic          den_neg, tn_neg;
    logic [PW-1:0] den_abs_w, tn_abs_w;
    logic [DW-1:0] den_abs;
    logic [PW:0]   tn_adj, un_adj, den_cmp;
    logic          t_in, u_in, parallel;
    t_status       n4_status;
    always_comb begin
        den_neg   = r3_den[PW-1];
        tn_neg    = r3_tn[PW-1];
        den_abs_w = den_neg ? PW'(-r3_den) : PW'(r3_den);
        tn_abs_w  = tn_neg ? PW'(-r3_tn) : PW'(r3_tn);
        den_abs   = den_abs_w[DW-1:0];
        parallel  = (r3_den == '0) || (CMPW'(den_abs) < CMPW'(r_thr));
        tn_adj    = den_neg ? -{r3_tn[PW-1], r3_tn} : {r3_tn[PW-1], r3_tn};
        un_adj    = den_neg ? -{r3_un[PW-1], r3_un} : {r3_un[PW-1], r3_un};
        den_cmp   = (PW+1)'(den_abs);
        t_in      = !tn_adj[PW] && (tn_adj <= den_cmp);
        u_in      = !un_adj[PW] && (un_adj <= den_cmp);
        if (parallel) begin
            n4_status = ST_PARALLEL;
        end else if (!t_in || !u_in) begin
            n4_status = ST_OUTSIDE;
        end else begin
            n4_status = ST_HIT;
        end
    end

    t_status              r4_status;
    logic [DW-1:0]        r4_den, r4_tn;
    logic [CW-1:0]        r4_dxm, r4_dym;
    logic                 r4_sx, r4_sy;
    logic signed [CW-1:0] r4_x1, r4_y1;
    logic [DFW-1:0]       dxm_w, dym_w;
    assign dxm_w = r3_dx[DFW-1] ? DFW'(-r3_dx) : DFW'(r3_dx);
    assign dym_w = r3_dy[DFW-1] ? DFW'(-r3_dy) : DFW'(r3_dy);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_status <= n4_status;
            r4_den    <= den_abs;
            r4_tn     <= tn_abs_w[DW-1:0];
            r4_dxm    <= dxm_w[CW-1:0];
            r4_dym    <= dym_w[CW-1:0];
            r4_sx     <= tn_neg ^ den_neg ^ r3_dx[DFW-1];
            r4_sy     <= tn_neg ^ den_neg ^ r3_dy[DFW-1];
            r4_x1     <= r3_x1;
            r4_y1     <= r3_y1;
        end
    end

    // Stage 5: dividends |tn| * |end - start| * 2^FRAC_BITS
    logic [NW-1:0]  r5_nx, r5_ny;
    logic [DW-1:0]  r5_den;
    logic [XSW-1:0] r5_xside;
    logic [YSW-1:0] r5_yside;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx    <= (NW'(r4_tn) * NW'(r4_dxm)) << FRAC_BITS;
            r5_ny    <= (NW'(r4_tn) * NW'(r4_dym)) << FRAC_BITS;
            r5_den   <= r4_den;
            r5_xside <= {r4_status, r4_sx, r4_x1};
            r5_yside <= {r4_sy, r4_y1};
        end
    end

    // Division, one quotient bit per stage
    logic [QW-1:0]  qx, qy;
    logic [XSW-1:0] xside;
    logic [YSW-1:0] yside;

    sip_div #(.DW(DW), .QW(QW), .SW(XSW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r5_nx),
        .i_den  (r5_den),
        .i_side (r5_xside),
        .o_quot (qx),
        .o_side (xside)
    );

    sip_div #(.DW(DW), .QW(QW), .SW(YSW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r5_ny),
        .i_den  (r5_den),
        .i_side (r5_yside),
        .o_quot (qy),
        .o_side (yside)
    );

    // Output stage: signed quotient plus start point, saturated to 24 bits; zero unless a hit
    function automatic logic [OUT_W-1:0] place(
        input logic                 neg,
        input logic signed [CW-1:0] start,
        input logic [QW-1:0]        q
    );
        logic signed [SATW-1:0] s_base;
        logic signed [SATW-1:0] s_q;
        logic signed [SATW-1:0] s_v;
        logic signed [SATW-1:0] s_lo;
        logic signed [SATW-1:0] s_hi;
        logic [OUT_W-1:0]       res;
        s_base = SATW'(start) <<< FRAC_BITS;
        s_q    = neg ? -SATW'(q) : SATW'(q);
        s_v    = s_base + s_q;
        s_lo   = -(SATW'(1) <<< (OUT_W - 1));
        s_hi   = (SATW'(1) <<< (OUT_W - 1)) - SATW'(1);
        if (s_v < s_lo) begin
            res = s_lo[OUT_W-1:0];
        end else if (s_v > s_hi) begin
            res = s_hi[OUT_W-1:0];
        end else begin
            res = s_v[OUT_W-1:0];
        end
        return res;
    endfunction

    t_status          fin_status;
    logic             hit;
    logic [1:0]       r_status;
    logic [OUT_W-1:0] r_cx, r_cy;
    assign fin_status = t_status'(xside[XSW-1 -: 2]);
    assign hit        = (fin_status == ST_HIT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= fin_status;
            r_cx     <= hit ? place(xside[CW], xside[CW-1:0], qx) : '0;
            r_cy     <= hit ? place(yside[CW], yside[CW-1:0], qy) : '0;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_status;
    assign o_out.cross_x = r_cx;
    assign o_out.cross_y = r_cy;

endmodule

`default_nettype wire
